// File: src/srbh_pkg.sv
// ----------------------------------------------------------------------------
// srbh_pkg: shared types and constants for the swept ray / box hit unit
// Widths of the fixed-point coordinate path, per-edge request layout and the
// divider stage record.
// ----------------------------------------------------------------------------
package srbh_pkg;

    localparam int COORD_BITS    = 20;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_EDGES     = 4;

    // derived widths
    localparam int EW = COORD_BITS + 1;     // box edge coordinate, signed
    localparam int SW = COORD_BITS - 1;     // box size, unsigned
    localparam int MW = COORD_BITS;         // magnitude of a ray component
    localparam int PW = EW + COORD_BITS;    // edge coordinate times ray component
    localparam int QW = PW + 1;             // difference of two such products
    localparam int UW = MW + SW;            // |ray component| times box size
    localparam int FW = FRACTION_BITS + 1;  // fraction incl. the 1.0 value

    localparam int DIV_STAGES  = FW;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_BOTTOM,
        EDGE_RIGHT,
        EDGE_TOP
    } edge_t;

    // one edge candidate: hit flag and the ratio num/den to resolve
    typedef struct packed {
        logic          ok;
        logic [MW-1:0] num;
        logic [MW-1:0] den;
    } lane_t;

    typedef lane_t [NUM_EDGES-1:0] cand_t;

    // one edge inside the divider pipe
    typedef struct packed {
        logic          ok;
        logic [MW-1:0] rem;
        logic [MW-1:0] den;
        logic [FW-1:0] quo;
    } div_lane_t;

    typedef div_lane_t [NUM_EDGES-1:0] div_stage_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: src/srbh_front.sv
// ----------------------------------------------------------------------------
// srbh_front: request intake and edge classification
// Registers the request, forms the cross products and reduces each edge test
// to a hit flag and one fraction num/den, then pushes it into the queue.
// ----------------------------------------------------------------------------
module srbh_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] dir_x,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] dir_y,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] box_left,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] box_top,
    input  logic        [srbh_pkg::COORD_BITS-2:0] box_width,
    input  logic        [srbh_pkg::COORD_BITS-2:0] box_height,
    input  srbh_pkg::q_status_t                    q_status,
    output logic                                   push,
    output srbh_pkg::cand_t                        push_data
);
    import srbh_pkg::*;

    // magnitude of an edge coordinate
    function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] n);
        logic [EW-1:0] res;
        res = n[EW-1] ? (~n + EW'(1)) : n;
        return res;
    endfunction

    // n/d within [0,1], or (0,1) when open_iv
    function automatic logic frac_in(
        input logic signed [EW-1:0] n,
        input logic                 d_neg,
        input logic [MW-1:0]        d_abs,
        input logic                 open_iv
    );
        logic [EW-1:0] an;
        logic          res;
        an = mag(n);
        if (n == '0)
        begin
            res = !open_iv;
        end
        else if (open_iv)
        begin
            res = (n[EW-1] == d_neg) && (an < {1'b0, d_abs});
        end
        else
        begin
            res = (n[EW-1] == d_neg) && (an <= {1'b0, d_abs});
        end
        return res;
    endfunction

    // one edge: m is the ray component across the edge, o the one along it
    function automatic lane_t edge_eval(
        input logic                 m_nz,
        input logic                 m_neg,
        input logic [MW-1:0]        m_abs,
        input logic                 o_nz,
        input logic                 o_neg,
        input logic [MW-1:0]        o_abs,
        input logic                 s_nz,
        input logic signed [EW-1:0] x,
        input logic signed [EW-1:0] q1,
        input logic signed [EW-1:0] q2,
        input logic signed [QW-1:0] qcr,
        input logic [UW-1:0]        span,
        input logic                 u_neg,
        input logic                 away
    );
        lane_t                res;
        logic                 u_ok;
        logic                 first;
        logic                 second;
        logic [EW-1:0]        m1;
        logic [EW-1:0]        m2;
        logic signed [QW-1:0] span_s;
        span_s = signed'(QW'(span));
        u_ok   = u_neg ? ((qcr <= 0) && (qcr >= -span_s))
                       : ((qcr >= 0) && (qcr <= span_s));
        res    = '0;
        if (m_nz && s_nz)
        begin
            // proper crossing; a start on an edge we leave does not count
            m1      = mag(x);
            res.ok  = frac_in(x, m_neg, m_abs, 1'b0) && u_ok && !((x == '0) && away);
            res.num = m1[MW-1:0];
            res.den = m_abs;
        end
        else if (!m_nz)
        begin
            // ray runs along the edge line: try its two end points
            first   = frac_in(q1, o_neg, o_abs, 1'b1);
            second  = frac_in(q2, o_neg, o_abs, 1'b1);
            m1      = mag(q1);
            m2      = mag(q2);
            res.ok  = (qcr == '0) && o_nz && (first || second);
            res.num = first ? m1[MW-1:0] : m2[MW-1:0];
            res.den = o_abs;
        end
        else
        begin
            // edge collapsed to a point
            m1      = mag(x);
            res.ok  = (qcr == '0) && frac_in(x, m_neg, m_abs, 1'b1);
            res.num = m1[MW-1:0];
            res.den = m_abs;
        end
        return res;
    endfunction

    logic                         adv;
    logic [MW-1:0]                ax_in;
    logic [MW-1:0]                ay_in;
    logic signed [EW-1:0]         r_in;
    logic signed [EW-1:0]         b_in;

    logic                         s1_valid_reg;
    logic signed [COORD_BITS-1:0] s1_rx_reg;
    logic signed [COORD_BITS-1:0] s1_ry_reg;
    logic [MW-1:0]                s1_ax_reg;
    logic [MW-1:0]                s1_ay_reg;
    logic signed [EW-1:0]         s1_l_reg;
    logic signed [EW-1:0]         s1_t_reg;
    logic signed [EW-1:0]         s1_r_reg;
    logic signed [EW-1:0]         s1_b_reg;
    logic [SW-1:0]                s1_w_reg;
    logic [SW-1:0]                s1_h_reg;

    logic                         s2_valid_reg;
    logic signed [COORD_BITS-1:0] s2_rx_reg;
    logic signed [COORD_BITS-1:0] s2_ry_reg;
    logic [MW-1:0]                s2_ax_reg;
    logic [MW-1:0]                s2_ay_reg;
    logic signed [EW-1:0]         s2_l_reg;
    logic signed [EW-1:0]         s2_t_reg;
    logic signed [EW-1:0]         s2_r_reg;
    logic signed [EW-1:0]         s2_b_reg;
    logic                         s2_w_nz_reg;
    logic                         s2_h_nz_reg;
    logic signed [PW-1:0]         s2_lry_reg;
    logic signed [PW-1:0]         s2_trx_reg;
    logic signed [PW-1:0]         s2_rry_reg;
    logic signed [PW-1:0]         s2_brx_reg;
    logic [UW-1:0]                s2_rxh_reg;
    logic [UW-1:0]                s2_ryw_reg;

    logic signed [PW-1:0]         lry_next;
    logic signed [PW-1:0]         trx_next;
    logic signed [PW-1:0]         rry_next;
    logic signed [PW-1:0]         brx_next;
    logic [UW-1:0]                rxh_next;
    logic [UW-1:0]                ryw_next;

    logic signed [QW-1:0]         q_left;
    logic signed [QW-1:0]         q_bottom;
    logic signed [QW-1:0]         q_right;
    logic signed [QW-1:0]         q_top;
    logic                         rx_nz;
    logic                         ry_nz;
    logic                         rx_neg;
    logic                         ry_neg;

    // whole front moves when its last stage is empty or drains into the queue
    assign adv      = !s2_valid_reg || !q_status.full;
    assign in_stall = !adv;
    assign push     = s2_valid_reg && !q_status.full;

    // intake: magnitudes and far box corners
    assign ax_in = dir_x[COORD_BITS-1] ? (~MW'(dir_x) + MW'(1)) : MW'(dir_x);
    assign ay_in = dir_y[COORD_BITS-1] ? (~MW'(dir_y) + MW'(1)) : MW'(dir_y);
    assign r_in  = EW'(box_left) + EW'(box_width);
    assign b_in  = EW'(box_top) + EW'(box_height);

    // products
    assign lry_next = PW'(s1_l_reg) * PW'(s1_ry_reg);
    assign trx_next = PW'(s1_t_reg) * PW'(s1_rx_reg);
    assign rry_next = PW'(s1_r_reg) * PW'(s1_ry_reg);
    assign brx_next = PW'(s1_b_reg) * PW'(s1_rx_reg);
    assign rxh_next = UW'(s1_ax_reg) * UW'(s1_h_reg);
    assign ryw_next = UW'(s1_ay_reg) * UW'(s1_w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rx_reg   <= dir_x;
            s1_ry_reg   <= dir_y;
            s1_ax_reg   <= ax_in;
            s1_ay_reg   <= ay_in;
            s1_l_reg    <= EW'(box_left);
            s1_t_reg    <= EW'(box_top);
            s1_r_reg    <= r_in;
            s1_b_reg    <= b_in;
            s1_w_reg    <= box_width;
            s1_h_reg    <= box_height;

            s2_rx_reg   <= s1_rx_reg;
            s2_ry_reg   <= s1_ry_reg;
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_l_reg    <= s1_l_reg;
            s2_t_reg    <= s1_t_reg;
            s2_r_reg    <= s1_r_reg;
            s2_b_reg    <= s1_b_reg;
            s2_w_nz_reg <= |s1_w_reg;
            s2_h_nz_reg <= |s1_h_reg;
            s2_lry_reg  <= lry_next;
            s2_trx_reg  <= trx_next;
            s2_rry_reg  <= rry_next;
            s2_brx_reg  <= brx_next;
            s2_rxh_reg  <= rxh_next;
            s2_ryw_reg  <= ryw_next;
        end
    end

    // edge classification
    assign q_left   = QW'(s2_lry_reg) - QW'(s2_trx_reg);
    assign q_bottom = QW'(s2_lry_reg) - QW'(s2_brx_reg);
    assign q_right  = QW'(s2_rry_reg) - QW'(s2_brx_reg);
    assign q_top    = QW'(s2_rry_reg) - QW'(s2_trx_reg);
    assign rx_nz    = |s2_rx_reg;
    assign ry_nz    = |s2_ry_reg;
    assign rx_neg   = s2_rx_reg[COORD_BITS-1];
    assign ry_neg   = s2_ry_reg[COORD_BITS-1];

    always_comb
    begin
        push_data[EDGE_LEFT] = edge_eval(rx_nz, rx_neg, s2_ax_reg, ry_nz, ry_neg, s2_ay_reg,
            s2_h_nz_reg, s2_l_reg, s2_t_reg, s2_b_reg, q_left, s2_rxh_reg,
            rx_neg, rx_neg);
        push_data[EDGE_BOTTOM] = edge_eval(ry_nz, ry_neg, s2_ay_reg, rx_nz, rx_neg, s2_ax_reg,
            s2_w_nz_reg, s2_b_reg, s2_l_reg, s2_r_reg, q_bottom, s2_ryw_reg,
            !ry_neg, ry_nz && !ry_neg);
        push_data[EDGE_RIGHT] = edge_eval(rx_nz, rx_neg, s2_ax_reg, ry_nz, ry_neg, s2_ay_reg,
            s2_h_nz_reg, s2_r_reg, s2_b_reg, s2_t_reg, q_right, s2_rxh_reg,
            !rx_neg, rx_nz && !rx_neg);
        push_data[EDGE_TOP] = edge_eval(ry_nz, ry_neg, s2_ay_reg, rx_nz, rx_neg, s2_ax_reg,
            s2_w_nz_reg, s2_t_reg, s2_r_reg, s2_l_reg, q_top, s2_ryw_reg,
            ry_neg, ry_neg);
    end

endmodule

// File: src/srbh_queue.sv
// ----------------------------------------------------------------------------
// srbh_queue: short request queue between classification and divider
// Small register FIFO; lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module srbh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srbh_pkg::cand_t     push_data,
    input  logic                pop,
    output srbh_pkg::cand_t     pop_data,
    output srbh_pkg::q_status_t q_status
);
    import srbh_pkg::*;

    cand_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign q_status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_AW + 1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue fill count above depth");
    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");
    ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: src/srbh_back.sv
// ----------------------------------------------------------------------------
// srbh_back: fraction divider and earliest-edge select
// Four restoring divider lanes, one quotient bit per stage, followed by the
// priority minimum over the edges and the result register.
// ----------------------------------------------------------------------------
module srbh_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  srbh_pkg::q_status_t                    q_status,
    input  srbh_pkg::cand_t                        pop_data,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   hit,
    output logic [srbh_pkg::FRACTION_BITS:0]       fraction,
    output logic [1:0]                             edge_normal
);
    import srbh_pkg::*;

    // integer bit of the quotient
    function automatic div_lane_t div_first(input lane_t c);
        div_lane_t nxt;
        nxt.ok  = c.ok;
        nxt.den = c.den;
        if (c.num >= c.den)
        begin
            nxt.rem = c.num - c.den;
            nxt.quo = FW'(1);
        end
        else
        begin
            nxt.rem = c.num;
            nxt.quo = '0;
        end
        return nxt;
    endfunction

    // one fraction bit
    function automatic div_lane_t div_step(input div_lane_t cur);
        div_lane_t     nxt;
        logic [MW:0]   sh;
        logic [MW:0]   diff;
        nxt  = cur;
        sh   = {cur.rem, 1'b0};
        diff = sh - {1'b0, cur.den};
        if (sh >= {1'b0, cur.den})
        begin
            nxt.rem = diff[MW-1:0];
            nxt.quo = {cur.quo[FW-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = sh[MW-1:0];
            nxt.quo = {cur.quo[FW-2:0], 1'b0};
        end
        return nxt;
    endfunction

    logic                              adv;
    logic [DIV_STAGES-1:0]             vld_reg;
    div_stage_t [DIV_STAGES-1:0]       stg_reg;
    div_stage_t [DIV_STAGES-1:0]       stg_next;
    logic                              found;
    logic [FW-1:0]                     best;
    edge_t                             best_edge;
    logic                              out_valid_reg;
    logic                              hit_reg;
    logic [FW-1:0]                     fraction_reg;
    edge_t                             edge_reg;

    // pipe advances unless a finished result is held by the receiver
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && !q_status.empty;

    // divider stages
    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            stg_next[0][k] = div_first(pop_data[k]);
        end
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            for (int k = 0; k < NUM_EDGES; k++)
            begin
                stg_next[i][k] = div_step(stg_reg[i-1][k]);
            end
        end
    end

    // earliest edge, ties keep the lower edge
    always_comb
    begin
        found     = 1'b0;
        best      = '0;
        best_edge = EDGE_LEFT;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            if (stg_reg[DIV_STAGES-1][k].ok &&
                (!found || (stg_reg[DIV_STAGES-1][k].quo < best)))
            begin
                found     = 1'b1;
                best      = stg_reg[DIV_STAGES-1][k].quo;
                best_edge = edge_t'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DIV_STAGES-2:0], pop};
            out_valid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg      <= stg_next;
            hit_reg      <= found;
            fraction_reg <= best;
            edge_reg     <= best_edge;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign fraction    = fraction_reg;
    assign edge_normal = edge_reg;

`ifndef SYNTHESIS
    ap_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> ((fraction_reg == '0) && (edge_reg == EDGE_LEFT)))
        else $error("miss result carries nonzero fields");
    ap_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (fraction_reg <= FRAC_ONE))
        else $error("hit fraction above one");
`endif

endmodule

// File: src/swept_ray_box_hit_fraction.sv
// ----------------------------------------------------------------------------
// swept_ray_box_hit_fraction: earliest hit of a ray on an axis-aligned box
// Ray from the origin to (dir_x, dir_y) against the box edges left, bottom,
// right, top; returns hit flag, hit fraction and edge code.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with dir_x, dir_y, box_left, box_top,
//   box_width, box_height. A request is taken on a clock edge with in_valid
//   high and in_stall low.
//   Result channel: out_valid / out_stall with hit, fraction, edge_normal;
//   one result per request, in request order.
//   Throughput: one request per cycle while in_stall is low. From the accepting
//   edge to out_valid a request passes the first intake stage, which loads at
//   that edge, the second intake stage, one queue slot, 17 divider stages (one
//   quotient bit each) and the result register, in that order.
//   A stalled result holds the divider pipe; the 4-entry queue keeps taking
//   requests until it fills, then in_stall rises.
//   Reset (rst_n low, asynchronous) empties the pipes and the queue; the
//   block takes a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module swept_ray_box_hit_fraction (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] dir_x,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] dir_y,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] box_left,
    input  logic signed [srbh_pkg::COORD_BITS-1:0] box_top,
    input  logic        [srbh_pkg::COORD_BITS-2:0] box_width,
    input  logic        [srbh_pkg::COORD_BITS-2:0] box_height,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   hit,
    output logic [srbh_pkg::FRACTION_BITS:0]       fraction,
    output logic [1:0]                             edge_normal
);
    import srbh_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    cand_t     push_data;
    cand_t     pop_data;

    srbh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    srbh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    srbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .fraction    (fraction),
        .edge_normal (edge_normal)
    );

endmodule

// File: dv/swept_ray_box_hit_fraction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swept_ray_box_hit_fraction_tb: self-checking bench for the ray / box hit unit
// Drives directed ray/box requests from a table, then random requests, with
// bursty input and a stalling receiver. Results are checked in request order
// against a ring of expected values: the typed table row or an edge-test model.
// ----------------------------------------------------------------------------
module swept_ray_box_hit_fraction_tb;
    import srbh_pkg::*;

    localparam int N_RANDOM  = 600;
    localparam int N_DIR     = 22;
    localparam int MAX_CYCLE = 400000;
    localparam int EXP_DEPTH = 1024;

    typedef struct {
        logic signed [COORD_BITS-1:0] dx, dy, bl, bt;
        logic [COORD_BITS-2:0]        bw, bh;
    } ray_req_t;

    typedef struct packed {
        logic          hit;
        logic [FW-1:0] frac;
        edge_t         nrm;
    } hit_res_t;

    typedef struct {
        ray_req_t req;
        logic     typed;   // expected result given in the table
        hit_res_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_BITS-1:0] dir_x = '0, dir_y = '0, box_left = '0, box_top = '0;
    logic [COORD_BITS-2:0] box_width = '0, box_height = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [FRACTION_BITS:0] fraction;
    logic [1:0] edge_normal;

    hit_res_t exp_ring[EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    dir_row_t dir_rows[N_DIR];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_hits = 0;
    int  cycle = 0;
    int  hold_cnt = 0;
    logic hold_long = 1'b0;
    logic hold_done = 1'b0;
    logic sent_all = 1'b0;

    always #5 clk = ~clk;

    swept_ray_box_hit_fraction u_top (.*);

    // trunc(n/d * 2^FRACTION_BITS), 0 <= n <= d
    function automatic logic [FW-1:0] frac_of(longint n, longint d);
        longint q, r;
        q = n / d;
        r = n - q * d;
        for (int i = 0; i < FRACTION_BITS; i++)
        begin
            r = r * 2;
            q = q * 2;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        return q[FW-1:0];
    endfunction

    // one edge q..q+s against ray r
    function automatic logic edge_cross(longint rx, longint ry, longint qx, longint qy,
                                        longint sx, longint sy,
                                        output logic [FW-1:0] fr, output logic at_zero);
        longint qcs, qcr, rcs, rdr, a, b;
        qcs = qx * sy - qy * sx;
        qcr = qx * ry - qy * rx;
        rcs = rx * sy - ry * sx;
        at_zero = 1'b0;
        fr = '0;
        if (rcs == 0)
        begin
            // parallel: only collinear overlaps count, strictly inside the ray
            rdr = rx * rx + ry * ry;
            if (qcr != 0 || rdr == 0)
                return 1'b0;
            a = qx * rx + qy * ry;
            if (a > 0 && a < rdr)
            begin
                fr = frac_of(a, rdr);
                return 1'b1;
            end
            b = (qx + sx) * rx + (qy + sy) * ry;
            if (b > 0 && b < rdr)
            begin
                fr = frac_of(b, rdr);
                return 1'b1;
            end
            return 1'b0;
        end
        if (rcs < 0)
        begin
            rcs = -rcs;
            qcs = -qcs;
            qcr = -qcr;
        end
        if (qcs < 0 || qcs > rcs || qcr < 0 || qcr > rcs)
            return 1'b0;
        fr = frac_of(qcs, rcs);
        at_zero = (qcs == 0);
        return 1'b1;
    endfunction

    function automatic hit_res_t earliest_hit(ray_req_t q);
        hit_res_t res;
        longint rx, ry, l, t, w, h;
        longint ex[4], ey[4], sx[4], sy[4];
        logic away[4];
        logic [FW-1:0] fr;
        logic z;
        rx = q.dx; ry = q.dy; l = q.bl; t = q.bt; w = q.bw; h = q.bh;
        ex = '{l, l, l + w, l + w};
        ey = '{t, t + h, t + h, t};
        sx = '{0, w, 0, -w};
        sy = '{h, 0, -h, 0};
        away = '{rx < 0, ry > 0, rx > 0, ry < 0};
        res = '{1'b0, '0, EDGE_LEFT};
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            if (!edge_cross(rx, ry, ex[k], ey[k], sx[k], sy[k], fr, z))
                continue;
            if (z && away[k])
                continue;
            if (!res.hit || fr < res.frac)
            begin
                res.hit = 1'b1;
                res.frac = fr;
                res.nrm = edge_t'(k);
            end
        end
        return res;
    endfunction

    function automatic ray_req_t rand_req();
        ray_req_t q;
        int mode;
        mode = $urandom_range(0, 9);
        q.dx = COORD_BITS'($urandom);
        q.dy = COORD_BITS'($urandom);
        q.bl = COORD_BITS'($urandom);
        q.bt = COORD_BITS'($urandom);
        q.bw = (COORD_BITS - 1)'($urandom);
        q.bh = (COORD_BITS - 1)'($urandom);
        if (mode < 6)
        begin
            // box placed along the ray so most requests hit
            q.bl = q.dx / $signed(COORD_BITS'($urandom_range(1, 8)))
                 - $signed(20'($urandom_range(0, 4000)));
            q.bt = q.dy / $signed(COORD_BITS'($urandom_range(1, 8)))
                 - $signed(20'($urandom_range(0, 4000)));
            q.bw = (COORD_BITS - 1)'($urandom_range(0, 8000));
            q.bh = (COORD_BITS - 1)'($urandom_range(0, 8000));
        end
        else if (mode == 6)
        begin
            // axis-aligned ray, collinear with an edge at times
            q.dy = '0;
            q.bt = ($urandom_range(0, 1)) ? '0 : -$signed(20'(q.bh));
        end
        else if (mode == 7)
        begin
            // box corner or edge at the origin
            q.bl = ($urandom_range(0, 1)) ? '0 : -$signed(20'(q.bw));
            q.bt = ($urandom_range(0, 1)) ? '0 : -$signed(20'(q.bh));
        end
        return q;
    endfunction

    function automatic ray_req_t mk(int dx, int dy, int bl, int bt, int bw, int bh);
        ray_req_t q;
        q.dx = COORD_BITS'(dx);
        q.dy = COORD_BITS'(dy);
        q.bl = COORD_BITS'(bl);
        q.bt = COORD_BITS'(bt);
        q.bw = (COORD_BITS - 1)'(bw);
        q.bh = (COORD_BITS - 1)'(bh);
        return q;
    endfunction

    initial
    begin
        // typed rows: misses and plain crossings easy to read
        dir_rows[0]  = '{mk(0, 0, -10, -10, 20, 20), 1, '{0, 0, EDGE_LEFT}};
        dir_rows[1]  = '{mk(512, 0, 256, -256, 256, 512), 1, '{1, 17'h8000, EDGE_LEFT}};
        dir_rows[2]  = '{mk(-512, 0, -256, -256, 0, 512), 1, '{1, 17'h8000, EDGE_LEFT}};
        dir_rows[3]  = '{mk(0, 512, -256, 256, 512, 0), 1, '{1, 17'h8000, EDGE_BOTTOM}};
        dir_rows[4]  = '{mk(512, 0, 512, -256, 256, 512), 1, '{1, FRAC_ONE, EDGE_LEFT}};
        dir_rows[5]  = '{mk(512, 0, 1024, -256, 256, 512), 1, '{0, 0, EDGE_LEFT}};
        dir_rows[6]  = '{mk(0, 0, 0, 0, 0, 0), 1, '{0, 0, EDGE_LEFT}};
        // remaining rows: extremes, collinear, away-at-zero, corners
        dir_rows[7]  = '{mk(524287, 524287, -524288, -524288, 524287, 524287), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[8]  = '{mk(-524288, -524288, 524287, 524287, 524287, 524287), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[9]  = '{mk(-524288, 524287, 0, 0, 524287, 0), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[10] = '{mk(1000, 0, 200, 0, 300, 100), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[11] = '{mk(1000, 0, -200, 0, 300, 100), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[12] = '{mk(-1000, 0, -500, -50, 600, 100), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[13] = '{mk(0, -1000, -10, -500, 20, 500), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[14] = '{mk(100, 50, 0, -10, 40, 20), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[15] = '{mk(-100, 50, -40, -10, 40, 20), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[16] = '{mk(50, 100, -10, -20, 20, 20), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[17] = '{mk(50, -100, -10, 0, 20, 20), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[18] = '{mk(300, 300, 100, 100, 0, 0), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[19] = '{mk(3, 7, 1, 2, 524287, 524287), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[20] = '{mk(524287, -1, 1, -524288, 1, 524287), 0, '{0, 0, EDGE_LEFT}};
        dir_rows[21] = '{mk(-1, 524287, -524288, 1, 524287, 1), 0, '{0, 0, EDGE_LEFT}};
    end

    // reset and cycle limit
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle, exp_wr - exp_rd);
            $display("** swept_ray_box_hit_fraction: FAILED **");
            $finish;
        end
    end

    task automatic send_req(ray_req_t q, logic typed, hit_res_t res);
        dir_x <= q.dx; dir_y <= q.dy; box_left <= q.bl; box_top <= q.bt;
        box_width <= q.bw; box_height <= q.bh;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed && res != earliest_hit(q))
            $display("note: table row disagrees with model for dx=%0d dy=%0d", q.dx, q.dy);
        exp_ring[exp_wr % EXP_DEPTH] = typed ? res : earliest_hit(q);
        exp_wr++;
    endtask

    // request side: bursts with random gaps
    initial
    begin
        int burst;
        ray_req_t q;
        @(posedge clk iff rst_n);
        for (int i = 0; i < N_DIR; i++)
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        in_valid <= 1'b0;
        // drain completely before the random part
        while (exp_wr != exp_rd)
            @(posedge clk);
        for (int i = 0; i < N_RANDOM; )
        begin
            burst = $urandom_range(1, 30);
            if (i >= 200)
                hold_long <= 1'b1;
            for (int j = 0; j < burst && i < N_RANDOM; j++, i++)
            begin
                q = rand_req();
                send_req(q, 1'b0, '{0, 0, EDGE_LEFT});
            end
            if (i > 80 && $urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        sent_all <= 1'b1;
    end

    // result side: stall pattern, with one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_long && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 120;
            out_stall <= 1'b1;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else
            out_stall <= (cycle % 64 < 20) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end

    // result checking
    always @(posedge clk)
    begin
        hit_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result hit=%0d frac=%0d edge=%0d",
                             hit, fraction, edge_normal);
            end
            else
            begin
                e = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                if (hit) n_hits++;
                if (hit !== e.hit || fraction !== e.frac || edge_normal !== e.nrm)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch #%0d: exp hit=%0d frac=%0d edge=%0d, got %0d %0d %0d",
                                 n_checked, e.hit, e.frac, e.nrm, hit, fraction, edge_normal);
                end
            end
        end
    end

    // end of run
    initial
    begin
        @(posedge clk iff sent_all);
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("ran %0d table rows and %0d random rays with bursty input, random stalls",
                 N_DIR, N_RANDOM);
        $display("and one long hold-off; checked %0d results (%0d hits), %0d mismatches",
                 n_checked, n_hits, n_errors);
        if (n_errors == 0 && exp_wr == exp_rd)
            $display("** swept_ray_box_hit_fraction: PASSED **");
        else
            $display("** swept_ray_box_hit_fraction: FAILED **");
        $finish;
    end

endmodule
